// ----- src/ccbd_pkg.sv -----
// ----------------------------------------------------------------------------
// ccbd_pkg
// Shared constants and types for the console CPU/PPU bus decoder.
// ----------------------------------------------------------------------------
package ccbd_pkg;

    // Storage sizes (powers of two)
    localparam int RAM_DEPTH  = 2048;
    localparam int VRAM_DEPTH = 2048;
    localparam int RAM_AW     = $clog2(RAM_DEPTH);
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int CLR_DEPTH  = (RAM_DEPTH > VRAM_DEPTH) ? RAM_DEPTH : VRAM_DEPTH;
    localparam int CLR_AW     = $clog2(CLR_DEPTH);

    // Request operation codes
    localparam logic [2:0] OP_CPU_READ  = 3'd0;
    localparam logic [2:0] OP_CPU_WRITE = 3'd1;
    localparam logic [2:0] OP_PPU_READ  = 3'd2;
    localparam logic [2:0] OP_PPU_WRITE = 3'd3;
    localparam logic [2:0] OP_LOAD_BTN  = 3'd4;

    // Route codes
    localparam logic [2:0] ROUTE_RAM  = 3'd0;
    localparam logic [2:0] ROUTE_PPU  = 3'd1;
    localparam logic [2:0] ROUTE_IO   = 3'd2;
    localparam logic [2:0] ROUTE_TEST = 3'd3;
    localparam logic [2:0] ROUTE_CART = 3'd4;
    localparam logic [2:0] ROUTE_VRAM = 3'd5;
    localparam logic [2:0] ROUTE_CHR  = 3'd6;

    // Configuration register indexes
    localparam logic [7:0] CFG_MIRROR_VERTICAL = 8'd0;
    localparam logic [7:0] CFG_FOUR_SCREEN     = 8'd1;

    // Address map
    localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
    localparam logic [15:0] ADDR_NT_END    = 16'h3000;
    localparam logic [15:0] ADDR_IO_BASE   = 16'h4000;
    localparam logic [15:0] ADDR_OAM_DMA   = 16'h4014;
    localparam logic [15:0] ADDR_JOY1      = 16'h4016;
    localparam logic [15:0] ADDR_TEST_BASE = 16'h4018;
    localparam logic [15:0] ADDR_CART_BASE = 16'h4020;

    // Controller -> datapath
    typedef struct packed {
        logic clear;   // clearing pass: zero one entry of each memory
        logic accept;  // take the request on the input ports
        logic load;    // move the finished result into the output register
    } ccbd_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;  // last entry of the clearing pass
    } ccbd_status_t;

endpackage

// ----- src/ccbd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccbd_ctrl
// Sequencer: clearing pass after reset, request accept, result hand-off.
// ----------------------------------------------------------------------------
module ccbd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ccbd_pkg::ccbd_cmd_t   cmd,
    input  ccbd_pkg::ccbd_status_t status
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.clear  = (state_reg == ST_CLEAR);
    assign cmd.accept = s_valid && (state_reg == ST_IDLE);
    assign cmd.load   = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign m_valid    = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (status.clear_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (cmd.accept) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (cmd.load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/ccbd_datapath.sv -----
// ----------------------------------------------------------------------------
// ccbd_datapath
// Address decode, work RAM, nametable VRAM, controller port, output register.
// ----------------------------------------------------------------------------
module ccbd_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ccbd_pkg::ccbd_cmd_t    cmd,
    output ccbd_pkg::ccbd_status_t status,
    input  logic                   cfg_write,
    input  logic [7:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic [2:0]             s_operation,
    input  logic [15:0]            s_address,
    input  logic [7:0]             s_write_value,
    input  logic                   s_cycle_odd,
    output logic [7:0]             m_read_data,
    output logic [2:0]             m_route,
    output logic [15:0]            m_forward_address,
    output logic [7:0]             m_forward_data,
    output logic                   m_dma_start,
    output logic [7:0]             m_dma_page,
    output logic                   m_dma_odd_delay,
    output logic                   m_controller_strobe
);

    typedef enum logic [1:0] {
        RD_NONE,
        RD_RAM,
        RD_VRAM,
        RD_BTN
    } rd_sel_t;

    logic [7:0] work_ram [ccbd_pkg::RAM_DEPTH];
    logic [7:0] name_table_ram [ccbd_pkg::VRAM_DEPTH];

    logic [ccbd_pkg::CLR_AW-1:0]  clr_cnt_reg;
    logic                         mirror_vertical_reg;
    logic                         four_screen_reg;
    logic [7:0]                   button_reg, button_next;
    logic                         strobe_reg, strobe_next;

    logic [7:0]                   ram_rdata_reg;
    logic [7:0]                   vram_rdata_reg;

    // Decoded request, held until the result is loaded
    rd_sel_t     rd_sel_reg, rd_sel_next;
    logic        btn_bit_reg;
    logic [2:0]  route_reg, route_next;
    logic [15:0] faddr_reg, faddr_next;
    logic [7:0]  fdata_reg, fdata_next;
    logic        dstart_reg, dstart_next;
    logic [7:0]  dpage_reg, dpage_next;
    logic        ddelay_reg, ddelay_next;

    logic                         ram_we, ram_re, vram_we, vram_re;
    logic [ccbd_pkg::RAM_AW-1:0]  ram_idx;
    logic [10:0]                  nt_idx;
    logic [ccbd_pkg::VRAM_AW-1:0] vram_idx;
    logic                         is_write;

    assign status.clear_last = (clr_cnt_reg == ccbd_pkg::CLR_AW'(ccbd_pkg::CLR_DEPTH - 1));

    assign ram_idx  = s_address[ccbd_pkg::RAM_AW-1:0];
    // vertical: A10 picks the screen; horizontal: A11 does
    assign nt_idx   = mirror_vertical_reg ? s_address[10:0]
                                          : {s_address[11], s_address[9:0]};
    assign vram_idx = ccbd_pkg::VRAM_AW'(nt_idx);

    always_comb begin
        rd_sel_next = RD_NONE;
        route_next  = ccbd_pkg::ROUTE_RAM;
        faddr_next  = '0;
        fdata_next  = '0;
        dstart_next = 1'b0;
        dpage_next  = '0;
        ddelay_next = 1'b0;
        button_next = button_reg;
        strobe_next = strobe_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        vram_we     = 1'b0;
        vram_re     = 1'b0;
        is_write    = (s_operation == ccbd_pkg::OP_CPU_WRITE) ||
                      (s_operation == ccbd_pkg::OP_PPU_WRITE);
        case (s_operation)
            ccbd_pkg::OP_CPU_READ, ccbd_pkg::OP_CPU_WRITE: begin
                if (s_address < ccbd_pkg::ADDR_PPU_BASE) begin
                    route_next = ccbd_pkg::ROUTE_RAM;
                    if (is_write) begin
                        ram_we = 1'b1;
                    end else begin
                        ram_re      = 1'b1;
                        rd_sel_next = RD_RAM;
                    end
                end else if (s_address < ccbd_pkg::ADDR_IO_BASE ||
                             s_address >= ccbd_pkg::ADDR_CART_BASE) begin
                    route_next = (s_address < ccbd_pkg::ADDR_IO_BASE) ?
                                 ccbd_pkg::ROUTE_PPU : ccbd_pkg::ROUTE_CART;
                    faddr_next = s_address;
                    if (is_write) begin
                        fdata_next = s_write_value;
                    end
                end else if (s_address < ccbd_pkg::ADDR_TEST_BASE) begin
                    route_next = ccbd_pkg::ROUTE_IO;
                    if (is_write) begin
                        if (s_address == ccbd_pkg::ADDR_OAM_DMA) begin
                            dstart_next = 1'b1;
                            dpage_next  = s_write_value;
                            ddelay_next = s_cycle_odd;
                        end else if (s_address == ccbd_pkg::ADDR_JOY1) begin
                            // only 0 and 1 change the strobe
                            if (s_write_value == 8'd0) begin
                                strobe_next = 1'b0;
                            end else if (s_write_value == 8'd1) begin
                                strobe_next = 1'b1;
                            end
                        end
                    end else if (s_address == ccbd_pkg::ADDR_JOY1) begin
                        rd_sel_next = RD_BTN;
                        button_next = {1'b0, button_reg[7:1]};
                    end
                end else begin
                    route_next = ccbd_pkg::ROUTE_TEST;
                end
            end
            ccbd_pkg::OP_PPU_READ, ccbd_pkg::OP_PPU_WRITE: begin
                if (s_address < ccbd_pkg::ADDR_PPU_BASE) begin
                    route_next = ccbd_pkg::ROUTE_CHR;
                    if (!is_write) begin
                        faddr_next = s_address;
                    end
                end else begin
                    route_next = ccbd_pkg::ROUTE_VRAM;
                    if (s_address < ccbd_pkg::ADDR_NT_END && !four_screen_reg) begin
                        if (is_write) begin
                            vram_we = 1'b1;
                        end else begin
                            vram_re     = 1'b1;
                            rd_sel_next = RD_VRAM;
                        end
                    end
                end
            end
            ccbd_pkg::OP_LOAD_BTN: begin
                route_next  = ccbd_pkg::ROUTE_IO;
                button_next = s_write_value;
            end
            default: begin
                route_next = ccbd_pkg::ROUTE_RAM;
            end
        endcase
    end

    // Memories: zeroed one entry at a time during the clearing pass after reset
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            work_ram[clr_cnt_reg[ccbd_pkg::RAM_AW-1:0]] <= 8'd0;
        end else if (cmd.accept && ram_we) begin
            work_ram[ram_idx] <= s_write_value;
        end
        if (cmd.accept && ram_re) begin
            ram_rdata_reg <= work_ram[ram_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            name_table_ram[clr_cnt_reg[ccbd_pkg::VRAM_AW-1:0]] <= 8'd0;
        end else if (cmd.accept && vram_we) begin
            name_table_ram[vram_idx] <= s_write_value;
        end
        if (cmd.accept && vram_re) begin
            vram_rdata_reg <= name_table_ram[vram_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg         <= '0;
            mirror_vertical_reg <= 1'b0;
            four_screen_reg     <= 1'b0;
            button_reg          <= 8'd0;
            strobe_reg          <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_write) begin
                case (cfg_index)
                    ccbd_pkg::CFG_MIRROR_VERTICAL: mirror_vertical_reg <= cfg_data[0];
                    ccbd_pkg::CFG_FOUR_SCREEN:     four_screen_reg     <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                button_reg <= button_next;
                strobe_reg <= strobe_next;
            end
        end
    end

    // Decoded fields; payload only
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rd_sel_reg  <= rd_sel_next;
            btn_bit_reg <= button_reg[0];
            route_reg   <= route_next;
            faddr_reg   <= faddr_next;
            fdata_reg   <= fdata_next;
            dstart_reg  <= dstart_next;
            dpage_reg   <= dpage_next;
            ddelay_reg  <= ddelay_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            case (rd_sel_reg)
                RD_RAM:  m_read_data <= ram_rdata_reg;
                RD_VRAM: m_read_data <= vram_rdata_reg;
                RD_BTN:  m_read_data <= {7'd0, btn_bit_reg};
                default: m_read_data <= 8'd0;
            endcase
            m_route             <= route_reg;
            m_forward_address   <= faddr_reg;
            m_forward_data      <= fdata_reg;
            m_dma_start         <= dstart_reg;
            m_dma_page          <= dpage_reg;
            m_dma_odd_delay     <= ddelay_reg;
            m_controller_strobe <= strobe_reg;
        end
    end

endmodule

// ----- src/console_cpu_bus_decoder.sv -----
// ----------------------------------------------------------------------------
// console_cpu_bus_decoder
// CPU/PPU bus decode with mirrored work RAM, nametable VRAM and IO ports.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  s_        s_valid/s_ready    operation, address, write_value, cycle_odd
//  m_        m_valid/m_ready    read_data, route, forward_address, forward_data,
//                               dma_start, dma_page, dma_odd_delay,
//                               controller_strobe
//  cfg_      cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
//  One request at a time: the accept step issues the RAM/VRAM access, the
//  finish step loads the output register from the registered read data.
//  After reset both memories are zeroed one entry at a time; s_ready stays
//  low until all CLR_DEPTH (2048) entries are cleared.
//  A stalled result holds the request in its finish step until m_ready.
// ----------------------------------------------------------------------------
module console_cpu_bus_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_value,
    input  logic        s_cycle_odd,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [2:0]  m_route,
    output logic [15:0] m_forward_address,
    output logic [7:0]  m_forward_data,
    output logic        m_dma_start,
    output logic [7:0]  m_dma_page,
    output logic        m_dma_odd_delay,
    output logic        m_controller_strobe
);

    ccbd_pkg::ccbd_cmd_t    cmd;
    ccbd_pkg::ccbd_status_t status;

    assign cfg_ready = 1'b1;

    ccbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    ccbd_datapath u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .status              (status),
        .cfg_write           (cfg_valid),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_operation         (s_operation),
        .s_address           (s_address),
        .s_write_value       (s_write_value),
        .s_cycle_odd         (s_cycle_odd),
        .m_read_data         (m_read_data),
        .m_route             (m_route),
        .m_forward_address   (m_forward_address),
        .m_forward_data      (m_forward_data),
        .m_dma_start         (m_dma_start),
        .m_dma_page          (m_dma_page),
        .m_dma_odd_delay     (m_dma_odd_delay),
        .m_controller_strobe (m_controller_strobe)
    );

endmodule
